@@ hdl/image_decode_sample_size_defines.svh @@
// Assertion macros used by the RTL top level
`ifndef IMAGE_DECODE_SAMPLE_SIZE_DEFINES_SVH
`define IMAGE_DECODE_SAMPLE_SIZE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IDSS_ASSERT_IMPLIES(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("lbl failed");

// plain invariant
`define IDSS_ASSERT_ALWAYS(lbl, clk, rst, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (c)) \
    else $error("lbl failed");

`endif

@@ hdl/idss_pkg.sv @@
package idss_pkg;
  localparam int DIM_W = 15;
  localparam int AREA_W = 30;
  localparam int OUT_W = 16;
  localparam int FREE_UPPER = 128;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] side;
    logic             side_free;
    logic             pix_free;
  } item_side_t;
endpackage

@@ hdl/idss_div.sv @@
// Restoring divider, one quotient bit per stage, no stall
module idss_div #(
  parameter int N  = 30,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [N-1:0]  dividend,
  input  logic [N-1:0]  divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [N-1:0]  quotient,
  output logic [N-1:0]  remainder,
  output logic [SW-1:0] side_out
);
  logic [N-1:0]  rem_q [0:N-1];
  logic [N-1:0]  quo_q [0:N-1];
  logic [N-1:0]  dvd_q [0:N-1];
  logic [N-1:0]  dsr_q [0:N-1];
  logic [SW-1:0] sb_q  [0:N-1];
  logic          vld_q [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N-1:0]  p_rem, p_quo, p_dvd, p_dsr;
    logic [SW-1:0] p_sb;
    logic          p_vld;
    logic [N:0]    t;
    logic          ge;
    if (i == 0) begin : g_first
      assign p_rem = '0;
      assign p_quo = '0;
      assign p_dvd = dividend;
      assign p_dsr = divisor;
      assign p_sb  = side_in;
      assign p_vld = in_valid;
    end else begin : g_next
      assign p_rem = rem_q[i-1];
      assign p_quo = quo_q[i-1];
      assign p_dvd = dvd_q[i-1];
      assign p_dsr = dsr_q[i-1];
      assign p_sb  = sb_q[i-1];
      assign p_vld = vld_q[i-1];
    end
    assign t  = {p_rem, p_dvd[N-1-i]};
    assign ge = (t >= {1'b0, p_dsr});
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= p_vld;
      end
      rem_q[i] <= ge ? N'(t - {1'b0, p_dsr}) : t[N-1:0];
      quo_q[i] <= {p_quo[N-2:0], ge};
      dvd_q[i] <= p_dvd;
      dsr_q[i] <= p_dsr;
      sb_q[i]  <= p_sb;
    end
  end

  assign out_valid = vld_q[N-1];
  assign quotient  = quo_q[N-1];
  assign remainder = rem_q[N-1];
  assign side_out  = sb_q[N-1];
endmodule

@@ hdl/idss_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per stage
module idss_sqrt #(
  parameter int N = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [N-1:0]     radicand,
  output logic             out_valid,
  output logic [N/2-1:0]   root,
  output logic             rem_nonzero
);
  localparam int S  = N / 2;
  localparam int RW = S + 2;

  logic [RW-1:0] rem_q  [0:S-1];
  logic [S-1:0]  root_q [0:S-1];
  logic [N-1:0]  rad_q  [0:S-1];
  logic          vld_q  [0:S-1];

  for (genvar i = 0; i < S; i++) begin : g_stage
    logic [RW-1:0] p_rem;
    logic [S-1:0]  p_root;
    logic [N-1:0]  p_rad;
    logic          p_vld;
    logic [RW+1:0] t, trial;
    logic          ge;
    if (i == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = radicand;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rem  = rem_q[i-1];
      assign p_root = root_q[i-1];
      assign p_rad  = rad_q[i-1];
      assign p_vld  = vld_q[i-1];
    end
    assign t     = {p_rem, p_rad[N-1-2*i -: 2]};
    assign trial = {2'b00, p_root, 2'b01};
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= p_vld;
      end
      rem_q[i]  <= ge ? RW'(t - trial) : t[RW-1:0];
      root_q[i] <= {p_root[S-2:0], ge};
      rad_q[i]  <= p_rad;
    end
  end

  assign out_valid   = vld_q[S-1];
  assign root        = root_q[S-1];
  assign rem_nonzero = (rem_q[S-1] != '0);
endmodule

@@ hdl/image_decode_sample_size.sv @@
// One item accepted every cycle.
// Latency is set by the 30-stage area divider and the 15-stage root.
// busy is never raised and the receiver cannot stall.
// rst (synchronous) clears every valid bit; the datapath holds no state.
`include "image_decode_sample_size_defines.svh"
module image_decode_sample_size (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [idss_pkg::DIM_W-1:0]    image_width,
  input  logic [idss_pkg::DIM_W-1:0]    image_height,
  input  logic [idss_pkg::DIM_W-1:0]    min_side_length,
  input  logic                          side_unconstrained,
  input  logic [idss_pkg::AREA_W-1:0]   max_num_pixels,
  input  logic                          pixels_unconstrained,
  output logic                          done,
  output logic [idss_pkg::OUT_W-1:0]    sample_size
);
  import idss_pkg::*;

  localparam int SQ_W    = AREA_W / 2;
  localparam int LATENCY = 1 + AREA_W + 1 + SQ_W + 2;
  localparam int SB_W    = $bits(item_side_t);

  assign busy = 1'b0;

  // stage: area product
  logic              s0_vld;
  logic [AREA_W-1:0] s0_area, s0_maxpix;
  item_side_t        s0_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= start;
    end
    s0_area   <= AREA_W'(image_width) * AREA_W'(image_height);
    s0_maxpix <= (max_num_pixels == '0) ? AREA_W'(1) : max_num_pixels;
    s0_sb.w         <= image_width;
    s0_sb.h         <= image_height;
    s0_sb.side      <= (min_side_length == '0) ? DIM_W'(1) : min_side_length;
    s0_sb.side_free <= side_unconstrained;
    s0_sb.pix_free  <= pixels_unconstrained;
  end

  logic              d_vld;
  logic [AREA_W-1:0] d_quo, d_rem;
  logic [SB_W-1:0]   d_sb_raw;

  idss_div #(.N(AREA_W), .SW(SB_W)) u_area_div (
    .clk, .rst,
    .in_valid (s0_vld),
    .dividend (s0_area),
    .divisor  (s0_maxpix),
    .side_in  (s0_sb),
    .out_valid(d_vld),
    .quotient (d_quo),
    .remainder(d_rem),
    .side_out (d_sb_raw)
  );

  // stage: ceiling of the quotient
  logic              c_vld;
  logic [AREA_W-1:0] c_q;
  item_side_t        c_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= d_vld;
    end
    c_q  <= d_quo + AREA_W'(d_rem != '0);
    c_sb <= item_side_t'(d_sb_raw);
  end

  logic              r_vld;
  logic [SQ_W-1:0]   r_root;
  logic              r_nz;
  logic              a_vld;
  logic [DIM_W-1:0]  a_quo, b_quo;
  logic              a_pfree, b_sfree;

  idss_sqrt #(.N(AREA_W)) u_root (
    .clk, .rst,
    .in_valid   (c_vld),
    .radicand   (c_q),
    .out_valid  (r_vld),
    .root       (r_root),
    .rem_nonzero(r_nz)
  );

  idss_div #(.N(DIM_W), .SW(1)) u_w_div (
    .clk, .rst,
    .in_valid (c_vld),
    .dividend (c_sb.w),
    .divisor  (c_sb.side),
    .side_in  (c_sb.pix_free),
    .out_valid(a_vld),
    .quotient (a_quo),
    .remainder(),
    .side_out (a_pfree)
  );

  idss_div #(.N(DIM_W), .SW(1)) u_h_div (
    .clk, .rst,
    .in_valid (c_vld),
    .dividend (c_sb.h),
    .divisor  (c_sb.side),
    .side_in  (c_sb.side_free),
    .out_valid(),
    .quotient (b_quo),
    .remainder(),
    .side_out (b_sfree)
  );

  // stage: pick initial size
  logic             k_zero;
  logic [OUT_W-1:0] k, lower, upper, initial_size;
  logic             f_vld;
  logic [OUT_W-1:0] f_init;

  always_comb begin
    k      = OUT_W'(r_root) + OUT_W'(r_nz);
    k_zero = (k == '0);
    lower  = (a_pfree || k_zero) ? OUT_W'(1) : k;
    if (b_sfree) begin
      upper = OUT_W'(FREE_UPPER);
    end else begin
      upper = OUT_W'((a_quo < b_quo) ? a_quo : b_quo);
    end
    if (upper < lower) begin
      initial_size = lower;
    end else if (a_pfree && b_sfree) begin
      initial_size = OUT_W'(1);
    end else if (b_sfree) begin
      initial_size = lower;
    end else begin
      initial_size = upper;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= a_vld & r_vld;
    end
    f_init <= initial_size;
  end

  // stage: rounding
  logic [OUT_W:0]   up8;
  logic [OUT_W-1:0] rounded;

  always_comb begin
    up8 = {1'b0, f_init} + (OUT_W+1)'(7);
    case (f_init) inside
      [0:1]:   rounded = OUT_W'(1);
      2:       rounded = OUT_W'(2);
      [3:4]:   rounded = OUT_W'(4);
      [5:8]:   rounded = OUT_W'(8);
      default: rounded = {up8[OUT_W-1:3], 3'b000};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_vld;
    end
    sample_size <= rounded;
  end

  `IDSS_ASSERT_IMPLIES(a_nonzero, clk, rst, done, sample_size != '0)
  `IDSS_ASSERT_IMPLIES(a_format, clk, rst, done,
    sample_size[2:0] == 3'b000 || sample_size == OUT_W'(1) ||
    sample_size == OUT_W'(2) || sample_size == OUT_W'(4))
  `IDSS_ASSERT_IMPLIES(a_latency, clk, rst, done, $past(start, LATENCY))
  `IDSS_ASSERT_ALWAYS(a_lanes_aligned, clk, rst, a_vld == r_vld)
endmodule

@@ bench/image_decode_sample_size_tb.sv @@
module image_decode_sample_size_tb;
  import idss_pkg::*;

  localparam int LATENCY = 49;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [DIM_W-1:0]    image_width = '0;
  logic [DIM_W-1:0]    image_height = '0;
  logic [DIM_W-1:0]    min_side_length = '0;
  logic                side_unconstrained = 1'b0;
  logic [AREA_W-1:0]   max_num_pixels = '0;
  logic                pixels_unconstrained = 1'b0;
  logic                done;
  logic [OUT_W-1:0]    sample_size;

  typedef struct {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  side;
    logic              side_free;
    logic [AREA_W-1:0] maxpix;
    logic              pix_free;
    int                fixed;    // -1: use predictor
  } request_t;

  logic [OUT_W-1:0] pending_sizes[$];
  int               mismatches = 0;
  int               idle_pct = 0;

  image_decode_sample_size i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .image_width(image_width), .image_height(image_height),
    .min_side_length(min_side_length), .side_unconstrained(side_unconstrained),
    .max_num_pixels(max_num_pixels), .pixels_unconstrained(pixels_unconstrained),
    .done(done), .sample_size(sample_size)
  );

  always #6 clk = ~clk;

  function automatic logic [OUT_W-1:0] predict_sample_size(request_t r);
    logic [31:0] area, mp, q, k, lower, upper, a, b, sd, init, res;
    area = r.w * r.h;
    if (r.pix_free) begin
      lower = 1;
    end else begin
      mp = (r.maxpix == 0) ? 32'd1 : 32'(r.maxpix);
      q = area / mp + ((area % mp) != 0 ? 32'd1 : 32'd0);
      k = 0;
      while (k * k < q) k++;
      lower = (k == 0) ? 32'd1 : k;
    end
    if (r.side_free) begin
      upper = FREE_UPPER;
    end else begin
      sd = (r.side == 0) ? 32'd1 : 32'(r.side);
      a = r.w / sd;
      b = r.h / sd;
      upper = (a < b) ? a : b;
    end
    if (upper < lower) init = lower;
    else if (r.pix_free && r.side_free) init = 1;
    else if (r.side_free) init = lower;
    else init = upper;
    if (init <= 8) begin
      res = 1;
      while (res < init) res = res << 1;
    end else begin
      res = (init + 7) / 8 * 8;
    end
    return res[OUT_W-1:0];
  endfunction

  // results are accepted on the edge ending the strobe cycle
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_sizes.size() == 0) begin
        $error("sample_size: unexpected item, actual %0d", sample_size);
        mismatches++;
      end else begin
        logic [OUT_W-1:0] exp_size;
        exp_size = pending_sizes.pop_front();
        if (sample_size !== exp_size) begin
          $error("sample_size: expected %0d, actual %0d", exp_size, sample_size);
          mismatches++;
        end
      end
    end
  end

  task automatic send_request(request_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    image_width <= r.w;
    image_height <= r.h;
    min_side_length <= r.side;
    side_unconstrained <= r.side_free;
    max_num_pixels <= r.maxpix;
    pixels_unconstrained <= r.pix_free;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_sizes.push_back(r.fixed >= 0 ? OUT_W'(r.fixed) : predict_sample_size(r));
  endtask

  function automatic request_t random_request();
    request_t r;
    int shape;
    shape = int'($urandom_range(9));
    r.fixed = -1;
    r.side_free = 1'($urandom_range(1));
    r.pix_free = 1'($urandom_range(1));
    if (shape < 5) begin
      r.w = DIM_W'($urandom);
      r.h = DIM_W'($urandom);
      r.side = DIM_W'($urandom_range(1, 600));
      r.maxpix = AREA_W'($urandom_range(1, 2000000));
    end else if (shape < 8) begin
      r.w = DIM_W'($urandom_range(1, 2000));
      r.h = DIM_W'($urandom_range(1, 2000));
      r.side = DIM_W'($urandom_range(1, 64));
      r.maxpix = AREA_W'($urandom_range(1, 5000));
    end else begin
      r.w = DIM_W'($urandom);
      r.h = DIM_W'($urandom);
      r.side = DIM_W'($urandom);
      r.maxpix = AREA_W'($urandom);
    end
    return r;
  endfunction

  // w, h, side, side_free, maxpix, pix_free, fixed result
  request_t directed[] = '{
    '{15'd640, 15'd480, 15'd100, 1'b1, 30'd1000, 1'b1, 1},
    '{15'h7FFF, 15'h7FFF, 15'd1, 1'b0, 30'h3FFFFFFF, 1'b0, 32768},
    '{15'h7FFF, 15'h7FFF, 15'd1, 1'b0, 30'd1, 1'b0, 32768},
    '{15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b0, 30'd1, 1'b0, 32768},
    '{15'd1, 15'd1, 15'd1, 1'b0, 30'd1, 1'b0, 1},
    '{15'd0, 15'd100, 15'd10, 1'b0, 30'd5, 1'b0, 1},
    '{15'd100, 15'd0, 15'd10, 1'b0, 30'd5, 1'b1, 1},
    '{15'd0, 15'd0, 15'd0, 1'b0, 30'd0, 1'b0, 1},
    '{15'd100, 15'd100, 15'd0, 1'b0, 30'd1, 1'b1, 104},
    '{15'd100, 15'd100, 15'd10, 1'b1, 30'd0, 1'b0, 104},
    '{15'd1000, 15'd1000, 15'd100, 1'b1, 30'd10000, 1'b0, 16},
    '{15'd1000, 15'd1000, 15'd300, 1'b0, 30'd10000, 1'b1, 4},
    '{15'd1000, 15'd1000, 15'd200, 1'b0, 30'd10000, 1'b0, 16},
    '{15'd1000, 15'd900, 15'd100, 1'b0, 30'd100000, 1'b1, 16},
    '{15'd6000, 15'd6000, 15'd1, 1'b0, 30'd1, 1'b1, 6000},
    '{15'd640, 15'd480, 15'd7, 1'b0, 30'd1, 1'b1, -1},
    '{15'd640, 15'd480, 15'd3, 1'b0, 30'd999, 1'b0, -1},
    '{15'h5555, 15'h2AAA, 15'h2AAA, 1'b0, 30'h2AAAAAAA, 1'b0, -1},
    '{15'h2AAA, 15'h5555, 15'h5555, 1'b1, 30'h15555555, 1'b0, -1},
    '{15'd4097, 15'd3, 15'd1, 1'b1, 30'd1, 1'b0, -1}
  };

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_request(directed[i]);
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 81 : (phase == 3) ? 16 : 0;
      for (int n = 0; n < 175; n++) send_request(random_request());
      if (phase == 1) begin
        // hold off until the pipeline has drained
        start <= 1'b0;
        while (pending_sizes.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;
    while (pending_sizes.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/idss_pkg.sv
hdl/idss_div.sv
hdl/idss_sqrt.sv
hdl/image_decode_sample_size.sv
bench/image_decode_sample_size_tb.sv
